// ===== rtl/core/dlp_pkg.sv =====
package dlp_pkg;

	localparam int LINE_BUFFER_SIZE = 64;
	localparam int PREFIX_LEN = 6;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_ARM = 2'd1;
	localparam logic [1:0] OP_CLR_ALIVE = 2'd2;

	localparam logic [1:0] PH_SPACE = 2'd0;
	localparam logic [1:0] PH_SIGN = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [15:0] NO_COMMA_DIST = 16'hFFFF;

	typedef struct packed {
		logic [15:0] distance_mm;
		logic        distance_ready;
		logic        link_alive;
		logic        line_discarded;
	} result_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h44;
			3'd1: ch = 8'h69;
			3'd2: ch = 8'h73;
			3'd3: ch = 8'h74;
			3'd4: ch = 8'h3A;
			3'd5: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/core/dlp_ifs.sv =====
interface dlp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface dlp_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance_mm;
	logic        distance_ready;
	logic        link_alive;
	logic        line_discarded;

	modport source (output valid, output distance_mm, output distance_ready,
		output link_alive, output line_discarded, input ready);
	modport sink (input valid, input distance_mm, input distance_ready,
		input link_alive, input line_discarded, output ready);
endinterface

// ===== rtl/core/dlp_parser.sv =====
module dlp_parser #(
	parameter int LINE_BUFFER_SIZE = dlp_pkg::LINE_BUFFER_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [1:0]        op,
	input  logic [7:0]        rx_byte,
	output dlp_pkg::result_t  res
);

	localparam int LW = $clog2(LINE_BUFFER_SIZE);
	localparam logic [LW-1:0] LAST_IDX = LW'(LINE_BUFFER_SIZE - 1);
	localparam logic [LW-1:0] PREFIX_END = LW'(dlp_pkg::PREFIX_LEN);

	logic [LW-1:0] len_q, len_d;
	logic          pok_q, pok_d;
	logic [1:0]    phase_q, phase_d;
	logic          neg_q, neg_d;
	logic [15:0]   acc_q, acc_d;
	logic          comma_q, comma_d;
	logic          ended_q, ended_d;
	logic          ovf_q, ovf_d;
	logic [15:0]   dist_q, dist_d;
	logic          ready_q, ready_d;
	logic          alive_q, alive_d;
	logic          clear;
	logic          discard;
	logic          is_digit;
	logic          is_space;

	always_comb begin
		is_digit = rx_byte inside {[dlp_pkg::CH_ZERO:dlp_pkg::CH_NINE]};
		is_space = rx_byte == dlp_pkg::CH_SPACE || rx_byte inside {[dlp_pkg::CH_TAB:dlp_pkg::CH_CR]};
	end

	always_comb begin
		len_d = len_q;
		pok_d = pok_q;
		phase_d = phase_q;
		neg_d = neg_q;
		acc_d = acc_q;
		comma_d = comma_q;
		ended_d = ended_q;
		ovf_d = ovf_q;
		dist_d = dist_q;
		ready_d = ready_q;
		alive_d = alive_q;
		clear = 1'b0;
		discard = 1'b0;
		case (op)
			dlp_pkg::OP_BYTE: begin
				alive_d = 1'b1;
				if (!ready_q && rx_byte != dlp_pkg::CH_CR) begin
					if (ovf_q || len_q >= LAST_IDX) begin
						ovf_d = 1'b1;
						if (rx_byte == dlp_pkg::CH_LF) begin
							clear = 1'b1;
							discard = 1'b1;
						end
					end else begin
						len_d = len_q + LW'(1);
						if (!ended_q) begin
							if (len_q < PREFIX_END) begin
								if (rx_byte != dlp_pkg::prefix_char(len_q[2:0]))
									pok_d = 1'b0;
							end else if (phase_q != dlp_pkg::PH_DONE) begin
								if (is_digit) begin
									acc_d = (acc_q << 3) + (acc_q << 1)
										+ {12'd0, rx_byte[3:0]};
									phase_d = dlp_pkg::PH_DIGITS;
								end else if (phase_q == dlp_pkg::PH_SPACE && is_space) begin
									phase_d = phase_q;
								end else if (phase_q == dlp_pkg::PH_SPACE &&
									(rx_byte == dlp_pkg::CH_PLUS ||
									rx_byte == dlp_pkg::CH_MINUS)) begin
									neg_d = rx_byte == dlp_pkg::CH_MINUS;
									phase_d = dlp_pkg::PH_SIGN;
								end else begin
									phase_d = dlp_pkg::PH_DONE;
								end
							end
							if (rx_byte == dlp_pkg::CH_COMMA)
								comma_d = 1'b1;
							if (rx_byte == dlp_pkg::CH_NUL)
								ended_d = 1'b1;
						end
						if (rx_byte == dlp_pkg::CH_LF) begin
							clear = 1'b1;
							if (len_q < PREFIX_END || !pok_q) begin
								discard = 1'b1;
							end else begin
								if (comma_q)
									dist_d = neg_q ? (~acc_q + 16'd1) : acc_q;
								else
									dist_d = dlp_pkg::NO_COMMA_DIST;
								ready_d = 1'b1;
							end
						end
					end
				end
			end
			dlp_pkg::OP_ARM: begin
				ready_d = 1'b0;
				clear = 1'b1;
			end
			dlp_pkg::OP_CLR_ALIVE: begin
				alive_d = 1'b0;
			end
			default: begin
			end
		endcase
		if (clear) begin
			len_d = '0;
			pok_d = 1'b1;
			phase_d = dlp_pkg::PH_SPACE;
			neg_d = 1'b0;
			acc_d = '0;
			comma_d = 1'b0;
			ended_d = 1'b0;
			ovf_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pok_q <= 1'b1;
			phase_q <= dlp_pkg::PH_SPACE;
			neg_q <= 1'b0;
			acc_q <= '0;
			comma_q <= 1'b0;
			ended_q <= 1'b0;
			ovf_q <= 1'b0;
			dist_q <= '0;
			ready_q <= 1'b0;
			alive_q <= 1'b0;
		end else if (en) begin
			len_q <= len_d;
			pok_q <= pok_d;
			phase_q <= phase_d;
			neg_q <= neg_d;
			acc_q <= acc_d;
			comma_q <= comma_d;
			ended_q <= ended_d;
			ovf_q <= ovf_d;
			dist_q <= dist_d;
			ready_q <= ready_d;
			alive_q <= alive_d;
		end
	end

	assign res.distance_mm = dist_d;
	assign res.distance_ready = ready_d;
	assign res.link_alive = alive_d;
	assign res.line_discarded = discard;

endmodule

// ===== rtl/core/dlp_out_stage.sv =====
module dlp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  dlp_pkg::result_t data,
	output logic             free,
	dlp_res_if.source        res
);

	logic             valid_q;
	dlp_pkg::result_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= data;
		end
	end

	assign res.valid = valid_q;
	assign res.distance_mm = data_q.distance_mm;
	assign res.distance_ready = data_q.distance_ready;
	assign res.link_alive = data_q.link_alive;
	assign res.line_discarded = data_q.line_discarded;

endmodule

// ===== rtl/core/distance_line_parser_top.sv =====
// distance line parser for a serial rangefinder link
// cmd channel: one item per received byte (op byte) or a control op (arm, clear alive)
// res channel: one item per cmd item, showing latched distance, ready flag,
//   alive flag and whether this byte ended a rejected or overlong line
// an accepted item is registered in an input stage, decoded by the parser
//   next-state logic and captured in the result register
// an item waits in the input stage while the result register is full; res.valid rises
//   once the item has been captured in the result register
// throughput: one item per cycle while res is not stalled, set by the parser update
//   (times-ten accumulate and prefix compare between input and result register)
// when res is stalled the result register holds its item, the input stage
//   holds the next one, and cmd.ready drops only once both are full
// reset clears the line state, latched distance, ready and alive flags,
//   and empties both stages
module distance_line_parser_top #(
	parameter int LINE_BUFFER_SIZE = dlp_pkg::LINE_BUFFER_SIZE
) (
	input  logic      clk,
	input  logic      arst_n,
	dlp_cmd_if.sink   cmd,
	dlp_res_if.source res
);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       byte_s1;
	logic             free;
	logic             go;
	dlp_pkg::result_t next_res;

	assign go = valid_s1 && free;
	assign cmd.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1 <= cmd.op;
			byte_s1 <= cmd.rx_byte;
		end
	end

	dlp_parser #(
		.LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(go),
		.op(op_s1),
		.rx_byte(byte_s1),
		.res(next_res)
	);

	dlp_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1),
		.data(next_res),
		.free(free),
		.res(res)
	);

endmodule

// ===== rtl/core/dlp_checker.sv =====
module dlp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_distance_mm,
	input logic        res_distance_ready,
	input logic        res_link_alive,
	input logic        res_line_discarded
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_distance_mm) &&
		$stable(res_distance_ready) && $stable(res_link_alive) &&
		$stable(res_line_discarded))
		else $error("result changed while stalled");

	a_discard_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_line_discarded |-> !res_distance_ready && res_link_alive)
		else $error("discarded line with ready flag set or link dead");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> ##2 res_valid)
		else $error("result missing two cycles after accept");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("cmd stalled with empty result register");

endmodule

bind distance_line_parser_top dlp_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_distance_mm(res.distance_mm),
	.res_distance_ready(res.distance_ready),
	.res_link_alive(res.link_alive),
	.res_line_discarded(res.line_discarded)
);
